FILE: hw/rtl/binned_coverage_accumulator_top_defines.svh
// assertion helpers for the binned coverage accumulator
`ifndef BINNED_COVERAGE_ACCUMULATOR_TOP_DEFINES_SVH
`define BINNED_COVERAGE_ACCUMULATOR_TOP_DEFINES_SVH

// checked only out of reset
`define BCA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define BCA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/bca_pkg.sv
package bca_pkg;

  localparam int MAX_REGIONS = 4096;
  localparam int REG_AW      = $clog2(MAX_REGIONS);
  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

  // request codes
  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_STATS = 2'd1;
  localparam logic [1:0] REQ_RUN   = 2'd2;

  // register indexes
  localparam logic [1:0] CFG_REGION_SIZE = 2'd0;
  localparam logic [1:0] CFG_MIN_BASES   = 2'd1;
  localparam logic [1:0] CFG_CONTIG_LEN  = 2'd2;

  localparam logic [15:0] RESET_REGION_SIZE = 16'd100;
  localparam logic [31:0] RESET_MIN_BASES   = 32'd100;
  localparam logic [31:0] RESET_CONTIG_LEN  = 32'd409600;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_STATS = 2'd1,
    OP_RUN   = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        unmapped;
    logic [31:0] ref_start;
    logic [31:0] ref_end;
    logic [11:0] scan_from_region;
  } in_item_t;

  typedef struct packed {
    logic [12:0] region_count;
    logic [12:0] regions_above;
    logic [43:0] total_bases;
    logic [43:0] bases_above;
    logic        run_found;
    logic [31:0] run_start_base;
    logic [31:0] run_end_base;
    logic [12:0] next_region;
  } out_item_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] ref_start;
    logic [31:0] ref_end;
    logic [11:0] scan;
  } cmd_t;

  typedef struct packed {
    logic [15:0] region_size;
    logic [31:0] min_bases;
    logic [31:0] contig_length;
  } cfg_t;

endpackage

FILE: hw/rtl/bca_front.sv
module bca_front (
  input  logic              in_valid,
  input  bca_pkg::in_item_t in_data,
  output logic              in_stall,
  input  logic              clearing,
  input  logic              fifo_full,
  output logic              fifo_push,
  output bca_pkg::cmd_t     fifo_cmd
);
  import bca_pkg::*;

  logic keep;

  // hold off while the store is cleared or the queue is full
  assign in_stall = fifo_full | clearing;

  // drop unmapped or empty adds and unknown requests
  always_comb begin
    keep               = 1'b0;
    fifo_cmd.op        = OP_ADD;
    fifo_cmd.ref_start = in_data.ref_start;
    fifo_cmd.ref_end   = in_data.ref_end;
    fifo_cmd.scan      = in_data.scan_from_region;
    case (in_data.req_type)
      REQ_ADD: begin
        keep        = !in_data.unmapped && (in_data.ref_end > in_data.ref_start);
        fifo_cmd.op = OP_ADD;
      end
      REQ_STATS: begin
        keep        = 1'b1;
        fifo_cmd.op = OP_STATS;
      end
      REQ_RUN: begin
        keep        = 1'b1;
        fifo_cmd.op = OP_RUN;
      end
      default: keep = 1'b0;
    endcase
  end

  assign fifo_push = in_valid && !in_stall && keep;

endmodule

FILE: hw/rtl/bca_fifo.sv
module bca_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bca_pkg::cmd_t wr_data,
  input  logic          pop,
  output bca_pkg::cmd_t rd_data,
  output logic          full,
  output logic          empty
);
  import bca_pkg::*;

  cmd_t                 entry_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wp_r, rp_r;
  logic [FIFO_AW:0]     cnt_r;

  assign full    = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = entry_r[rp_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) entry_r[wp_r] <= wr_data;
  end

endmodule

FILE: hw/rtl/bca_back.sv
module bca_back (
  input  logic               clk,
  input  logic               rst_n,
  input  bca_pkg::cfg_t      cfg,
  input  logic               fifo_empty,
  input  bca_pkg::cmd_t      fifo_data,
  output logic               fifo_pop,
  output logic               clearing,
  output logic               out_valid,
  output bca_pkg::out_item_t out_data,
  input  logic               out_stall
);
  import bca_pkg::*;
  `include "binned_coverage_accumulator_top_defines.svh"

  typedef enum logic [10:0] {
    ST_CLR  = 11'b00000000001,
    ST_IDLE = 11'b00000000010,
    ST_DIVC = 11'b00000000100,
    ST_DIVS = 11'b00000001000,
    ST_ARD  = 11'b00000010000,
    ST_AWR  = 11'b00000100000,
    ST_SRD  = 11'b00001000000,
    ST_SAC  = 11'b00010000000,
    ST_RRD  = 11'b00100000000,
    ST_RAC  = 11'b01000000000,
    ST_FIN  = 11'b10000000000
  } state_t;

  state_t      state_r, state_nxt;
  logic [REG_AW-1:0] clr_r, clr_nxt;
  cmd_t        cmd_r, cmd_nxt;
  logic [12:0] count_r, count_nxt;
  logic [31:0] div_q_r, div_q_nxt;
  logic [15:0] div_rem_r, div_rem_nxt;
  logic [4:0]  div_cnt_r, div_cnt_nxt;
  logic [12:0] r_r, r_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [31:0] lo_r, lo_nxt;
  logic [31:0] b_r, b_nxt;
  logic [31:0] inc_r, inc_nxt;
  logic [12:0] above_r, above_nxt;
  logic [43:0] total_r, total_nxt;
  logic [43:0] tabove_r, tabove_nxt;
  logic [31:0] base_r, base_nxt;
  logic        found_r, found_nxt;
  logic [31:0] first_r, first_nxt;
  logic [31:0] endb_r, endb_nxt;
  logic [12:0] next_r, next_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_r, out_nxt;

  logic [31:0] mem [MAX_REGIONS];
  logic [31:0] rd_data_r;
  logic              mem_we;
  logic [REG_AW-1:0] mem_wa;
  logic [31:0]       mem_wd;

  logic [15:0] eff_size;
  logic [16:0] rem_sh;
  logic        div_ge;
  logic [16:0] rem_sub;
  logic [15:0] rem_new;
  logic [31:0] q_new;
  logic [12:0] cnt_val;
  logic [27:0] scan_prod;
  logic [32:0] hi;
  logic [32:0] sum;
  logic        qual;

  assign eff_size  = (cfg.region_size == '0) ? 16'd1 : cfg.region_size;
  assign clearing  = (state_r == ST_CLR);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign qual      = rd_data_r > cfg.min_bases;
  assign scan_prod = cmd_r.scan * eff_size;

  // one restoring division step per cycle
  always_comb begin
    rem_sh  = {div_rem_r, div_q_r[31]};
    rem_sub = rem_sh - {1'b0, eff_size};
    div_ge  = rem_sh >= {1'b0, eff_size};
    rem_new = div_ge ? rem_sub[15:0] : rem_sh[15:0];
    q_new   = {div_q_r[30:0], div_ge};
  end

  // regions in use from the finished quotient
  always_comb begin
    if (cfg.contig_length == '0) begin
      cnt_val = '0;
    end else if (q_new >= 32'(MAX_REGIONS - 1)) begin
      cnt_val = 13'(MAX_REGIONS);
    end else begin
      cnt_val = q_new[12:0] + 13'd1;
    end
  end

  assign hi  = {1'b0, lo_r} + {17'b0, eff_size};
  assign sum = {1'b0, rd_data_r} + {1'b0, inc_r};

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cmd_nxt       = cmd_r;
    count_nxt     = count_r;
    div_q_nxt     = div_q_r;
    div_rem_nxt   = div_rem_r;
    div_cnt_nxt   = div_cnt_r;
    r_nxt         = r_r;
    pos_nxt       = pos_r;
    lo_nxt        = lo_r;
    b_nxt         = b_r;
    inc_nxt       = inc_r;
    above_nxt     = above_r;
    total_nxt     = total_r;
    tabove_nxt    = tabove_r;
    base_nxt      = base_r;
    found_nxt     = found_r;
    first_nxt     = first_r;
    endb_nxt      = endb_r;
    next_nxt      = next_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    fifo_pop      = 1'b0;
    mem_we        = 1'b0;
    mem_wa        = r_r[REG_AW-1:0];
    mem_wd        = '0;
    case (state_r)
      ST_CLR: begin
        mem_we  = 1'b1;
        mem_wa  = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == REG_AW'(MAX_REGIONS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (!fifo_empty) begin
          fifo_pop    = 1'b1;
          cmd_nxt     = fifo_data;
          div_q_nxt   = cfg.contig_length - 32'd1;
          div_rem_nxt = '0;
          div_cnt_nxt = 5'd31;
          state_nxt   = ST_DIVC;
        end
      end
      ST_DIVC: begin
        div_q_nxt   = q_new;
        div_rem_nxt = rem_new;
        div_cnt_nxt = div_cnt_r - 5'd1;
        if (div_cnt_r == '0) begin
          count_nxt = cnt_val;
          case (cmd_r.op)
            OP_ADD: begin
              if (cnt_val == '0) begin
                state_nxt = ST_IDLE;
              end else begin
                div_q_nxt   = cmd_r.ref_start;
                div_rem_nxt = '0;
                div_cnt_nxt = 5'd31;
                state_nxt   = ST_DIVS;
              end
            end
            OP_STATS: begin
              r_nxt      = '0;
              above_nxt  = '0;
              total_nxt  = '0;
              tabove_nxt = '0;
              state_nxt  = ST_SRD;
            end
            OP_RUN: begin
              r_nxt     = {1'b0, cmd_r.scan};
              base_nxt  = {4'b0, scan_prod};
              found_nxt = 1'b0;
              first_nxt = '0;
              endb_nxt  = '0;
              state_nxt = ST_RRD;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_DIVS: begin
        div_q_nxt   = q_new;
        div_rem_nxt = rem_new;
        div_cnt_nxt = div_cnt_r - 5'd1;
        if (div_cnt_r == '0) begin
          if (q_new >= {19'b0, count_r}) begin
            state_nxt = ST_IDLE;
          end else begin
            r_nxt     = q_new[12:0];
            pos_nxt   = cmd_r.ref_start;
            lo_nxt    = cmd_r.ref_start - {16'b0, rem_new};
            state_nxt = ST_ARD;
          end
        end
      end
      // clip the span to this region while the counter is read
      ST_ARD: begin
        b_nxt     = ({1'b0, cmd_r.ref_end} < hi) ? cmd_r.ref_end : hi[31:0];
        inc_nxt   = (({1'b0, cmd_r.ref_end} < hi) ? cmd_r.ref_end : hi[31:0]) - pos_r;
        lo_nxt    = hi[31:0];
        state_nxt = ST_AWR;
      end
      // saturating update
      ST_AWR: begin
        mem_we  = 1'b1;
        mem_wd  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        pos_nxt = b_r;
        r_nxt   = r_r + 13'd1;
        if (b_r >= cmd_r.ref_end || (r_r + 13'd1) >= count_r) state_nxt = ST_IDLE;
        else state_nxt = ST_ARD;
      end
      ST_SRD: begin
        state_nxt = (r_r >= count_r) ? ST_FIN : ST_SAC;
      end
      ST_SAC: begin
        total_nxt = total_r + {12'b0, rd_data_r};
        if (qual) begin
          above_nxt  = above_r + 13'd1;
          tabove_nxt = tabove_r + {12'b0, rd_data_r};
        end
        r_nxt     = r_r + 13'd1;
        state_nxt = ST_SRD;
      end
      // run reaching the last region ends at the contig end
      ST_RRD: begin
        if (r_r >= count_r) begin
          endb_nxt  = cfg.contig_length;
          next_nxt  = count_r;
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_RAC;
        end
      end
      ST_RAC: begin
        if (found_r && !qual) begin
          endb_nxt  = base_r;
          next_nxt  = r_r;
          state_nxt = ST_FIN;
        end else begin
          if (!found_r && qual) begin
            found_nxt = 1'b1;
            first_nxt = base_r;
          end
          r_nxt     = r_r + 13'd1;
          base_nxt  = base_r + {16'b0, eff_size};
          state_nxt = ST_RRD;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt              = '0;
          out_nxt.region_count = count_r;
          if (cmd_r.op == OP_STATS) begin
            out_nxt.regions_above = above_r;
            out_nxt.total_bases   = total_r;
            out_nxt.bases_above   = tabove_r;
          end else begin
            out_nxt.run_found      = found_r;
            out_nxt.run_start_base = found_r ? first_r : '0;
            out_nxt.run_end_base   = found_r ? endb_r : '0;
            out_nxt.next_region    = next_r;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      div_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      div_cnt_r   <= div_cnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    count_r   <= count_nxt;
    div_q_r   <= div_q_nxt;
    div_rem_r <= div_rem_nxt;
    r_r       <= r_nxt;
    pos_r     <= pos_nxt;
    lo_r      <= lo_nxt;
    b_r       <= b_nxt;
    inc_r     <= inc_nxt;
    above_r   <= above_nxt;
    total_r   <= total_nxt;
    tabove_r  <= tabove_nxt;
    base_r    <= base_nxt;
    found_r   <= found_nxt;
    first_r   <= first_nxt;
    endb_r    <= endb_nxt;
    next_r    <= next_nxt;
    out_r     <= out_nxt;
  end

  // coverage counter store
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data_r <= mem[r_r[REG_AW-1:0]];
  end

  `BCA_ASSERT(a_out_from_fin, $rose(out_valid_r) |-> $past(state_r == ST_FIN), "result without finish")
  `BCA_ASSERT(a_write_in_range, (state_r == ST_AWR) |-> (r_r < count_r), "update beyond regions in use")
  `BCA_ASSERT_ALWAYS(a_clr_quiet, (rst_n && state_r == ST_CLR) |-> (!out_valid_r && !fifo_pop), "activity during clear")

endmodule

FILE: hw/rtl/binned_coverage_accumulator_top.sv
// binned coverage accumulator: region counters with span adds and region walks
// sequence: an add divides for the region count and the start region, then reads and
//   updates each region touched; queries divide for the region count, then walk regions
// throughput: one item at a time in the back end, set by the shared 1-bit/cycle divider
//   and the counter memory (a read and an update state per region); a 2-entry queue buffers input
// reset: synchronous active-low; control and config registers take reset values, then a clear
//   pass zeroes the counter memory while input is stalled (config writes still taken)
module binned_coverage_accumulator_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  bca_pkg::in_item_t  in_data,
  output logic               in_stall,
  output logic               out_valid,
  output bca_pkg::out_item_t out_data,
  input  logic               out_stall,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import bca_pkg::*;

  cfg_t cfg_r;
  logic clearing;
  logic fifo_push, fifo_pop, fifo_full, fifo_empty;
  cmd_t push_cmd, pop_cmd;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.region_size   <= RESET_REGION_SIZE;
      cfg_r.min_bases     <= RESET_MIN_BASES;
      cfg_r.contig_length <= RESET_CONTIG_LEN;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_REGION_SIZE: cfg_r.region_size   <= cfg_data[15:0];
        CFG_MIN_BASES:   cfg_r.min_bases     <= cfg_data;
        CFG_CONTIG_LEN:  cfg_r.contig_length <= cfg_data;
        default: ;
      endcase
    end
  end

  bca_front u_front (
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .clearing  (clearing),
    .fifo_full (fifo_full),
    .fifo_push (fifo_push),
    .fifo_cmd  (push_cmd)
  );

  bca_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (fifo_push),
    .wr_data (push_cmd),
    .pop     (fifo_pop),
    .rd_data (pop_cmd),
    .full    (fifo_full),
    .empty   (fifo_empty)
  );

  bca_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .fifo_empty (fifo_empty),
    .fifo_data  (pop_cmd),
    .fifo_pop   (fifo_pop),
    .clearing   (clearing),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .out_stall  (out_stall)
  );

endmodule
